>>> design/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

    localparam int HEADER_BYTES    = 16;
    localparam int MAX_FREE_BLOCKS = 16;
    localparam int MAX_USED_BLOCKS = 16;
    localparam int ADDR_BITS       = 16;

    localparam int HEAP_W   = 16;
    localparam int SIZE_W   = 16;
    localparam int FIDX_W   = $clog2(MAX_FREE_BLOCKS);
    localparam int UIDX_W   = $clog2(MAX_USED_BLOCKS);
    localparam int FCNT_W   = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int MAX_BLKS = (MAX_FREE_BLOCKS > MAX_USED_BLOCKS) ?
                              MAX_FREE_BLOCKS : MAX_USED_BLOCKS;
    localparam int WALK_W   = $clog2(MAX_BLKS + 1);

    localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(4096);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic        op;
        logic [15:0] req_size;
        logic [15:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [15:0] payload_addr;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic exhausted;
    } stat_t;

endpackage
`default_nettype wire

>>> design/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           start,
    input  ffba_pkg::stat_t st,
    output ffba_pkg::cmd_t  cmd,
    output logic          busy
);
    import ffba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (st.match || st.exhausted)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> state_reg == S_WALK)
        else $error("accepted request did not start a walk");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == S_IDLE)
        else $error("controller stayed busy after finishing");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.finish}))
        else $error("controller issued two commands at once");

endmodule
`default_nettype wire

>>> design/ffba_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_dp (
    input  wire                    clk,
    input  wire                    rst_n,
    input  ffba_pkg::cmd_t         cmd,
    output ffba_pkg::stat_t        st,
    input  ffba_pkg::req_t         req,
    input  wire                    cfg_we,
    input  wire [ffba_pkg::HEAP_W-1:0] cfg_data,
    output ffba_pkg::rsp_t         rsp,
    output logic                   done
);
    import ffba_pkg::*;

    logic [ADDR_BITS-1:0] fs_reg [MAX_FREE_BLOCKS];
    logic [ADDR_BITS-1:0] fs_next[MAX_FREE_BLOCKS];
    logic [SIZE_W-1:0]    fb_reg [MAX_FREE_BLOCKS];
    logic [SIZE_W-1:0]    fb_next[MAX_FREE_BLOCKS];
    logic [FCNT_W-1:0]    fe_reg, fe_next;
    logic [ADDR_BITS-1:0] us_reg [MAX_USED_BLOCKS];
    logic [SIZE_W-1:0]    ub_reg [MAX_USED_BLOCKS];
    logic [MAX_USED_BLOCKS-1:0] uv_reg, uv_next;
    logic                 uw_en;
    logic [UIDX_W-1:0]    uw_idx;
    logic [ADDR_BITS-1:0] uw_start;
    logic [SIZE_W-1:0]    uw_bytes;
    req_t                 req_reg;
    logic [WALK_W-1:0]    idx_reg, idx_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 done_reg;

    logic [FIDX_W-1:0]    fit;
    logic [UIDX_W-1:0]    hit;
    logic                 slot_found;
    logic [UIDX_W-1:0]    slot_idx;
    logic [ADDR_BITS-1:0] blk_start;
    logic [SIZE_W-1:0]    blk_bytes;
    logic                 zero_size;
    logic                 in_list;

    assign fit       = idx_reg[FIDX_W-1:0];
    assign hit       = idx_reg[UIDX_W-1:0];
    assign zero_size = (req_reg.req_size == '0);
    assign in_list   = (WALK_W'(idx_reg) < WALK_W'(fe_reg));
    assign blk_start = fs_reg[fit];
    assign blk_bytes = fb_reg[fit];

    always_comb
    begin
        if (req_reg.op == OP_ALLOC)
        begin
            st.match     = !zero_size && in_list && (blk_bytes >= req_reg.req_size);
            st.exhausted = zero_size || !in_list;
        end
        else
        begin
            st.match     = uv_reg[hit] &&
                           (ADDR_BITS'(us_reg[hit] + ADDR_BITS'(HEADER_BYTES))
                            == ADDR_BITS'(req_reg.free_addr));
            st.exhausted = (hit == UIDX_W'(MAX_USED_BLOCKS - 1));
        end
    end

    // Lowest free record of the used table.
    always_comb
    begin
        slot_found = 1'b0;
        slot_idx   = '0;
        for (int i = MAX_USED_BLOCKS - 1; i >= 0; i--)
        begin
            if (!uv_reg[i])
            begin
                slot_found = 1'b1;
                slot_idx   = UIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        fs_next  = fs_reg;
        fb_next  = fb_reg;
        fe_next  = fe_reg;
        uv_next  = uv_reg;
        uw_en    = 1'b0;
        uw_idx   = slot_idx;
        uw_start = blk_start;
        uw_bytes = blk_bytes;
        rsp_next = rsp_reg;
        idx_next = idx_reg;

        if (cmd.load)
            idx_next = '0;
        else if (cmd.step)
            idx_next = idx_reg + WALK_W'(1);

        if (cfg_we)
        begin
            fs_next[0] = '0;
            fb_next[0] = (cfg_data > HEAP_W'(HEADER_BYTES)) ?
                         SIZE_W'(cfg_data - HEAP_W'(HEADER_BYTES)) : '0;
            fe_next    = FCNT_W'(1);
            uv_next    = '0;
        end
        else if (cmd.finish)
        begin
            rsp_next.payload_addr = '0;
            if (req_reg.op == OP_ALLOC)
            begin
                if (!st.match)
                    rsp_next.status = ST_NO_FIT;
                else if (!slot_found)
                    rsp_next.status = ST_FULL;
                else
                begin
                    rsp_next.status       = ST_OK;
                    rsp_next.payload_addr = 16'(blk_start + ADDR_BITS'(HEADER_BYTES));
                    uw_en                 = 1'b1;
                    uv_next[slot_idx]     = 1'b1;
                    if ({1'b0, blk_bytes} >
                        ({1'b0, req_reg.req_size} + (SIZE_W+1)'(HEADER_BYTES)))
                    begin
                        // Split: the remainder stays in the block's list place.
                        fs_next[fit] = ADDR_BITS'(blk_start + ADDR_BITS'(HEADER_BYTES)
                                       + ADDR_BITS'(req_reg.req_size));
                        fb_next[fit] = blk_bytes - req_reg.req_size
                                       - SIZE_W'(HEADER_BYTES);
                        uw_bytes     = req_reg.req_size;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_FREE_BLOCKS - 1; i++)
                        begin
                            if ((i >= int'(fit)) && (i + 1 < int'(fe_reg)))
                            begin
                                fs_next[i] = fs_reg[i+1];
                                fb_next[i] = fb_reg[i+1];
                            end
                        end
                        fe_next = fe_reg - FCNT_W'(1);
                    end
                end
            end
            else
            begin
                if (!st.match)
                    rsp_next.status = ST_UNKNOWN;
                else if (fe_reg >= FCNT_W'(MAX_FREE_BLOCKS))
                    rsp_next.status = ST_FULL;
                else
                begin
                    rsp_next.status = ST_OK;
                    for (int i = 1; i < MAX_FREE_BLOCKS; i++)
                    begin
                        fs_next[i] = fs_reg[i-1];
                        fb_next[i] = fb_reg[i-1];
                    end
                    fs_next[0]  = us_reg[hit];
                    fb_next[0]  = ub_reg[hit];
                    fe_next     = fe_reg + FCNT_W'(1);
                    uv_next[hit] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FREE_BLOCKS; i++)
            begin
                fs_reg[i] <= '0;
                fb_reg[i] <= '0;
            end
            fb_reg[0] <= SIZE_W'(HEAP_RESET - HEAP_W'(HEADER_BYTES));
            fe_reg    <= FCNT_W'(1);
            uv_reg    <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            fs_reg   <= fs_next;
            fb_reg   <= fb_next;
            fe_reg   <= fe_next;
            uv_reg   <= uv_next;
            idx_reg  <= idx_next;
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        rsp_reg <= rsp_next;
        if (uw_en)
        begin
            us_reg[uw_idx] <= uw_start;
            ub_reg[uw_idx] <= uw_bytes;
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

    a_fe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fe_reg <= FCNT_W'(MAX_FREE_BLOCKS))
        else $error("free list count overflowed");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.finish))
        else $error("result word without a finished walk");

endmodule
`default_nettype wire

>>> design/first_fit_block_allocator.sv
// Channel   | Handshake             | Payload
// request   | start / busy          | req (req_t: op, req_size, free_addr)
// result    | done (one-cycle strobe)| rsp (rsp_t: payload_addr, status)
// config    | cfg_valid / cfg_ready | cfg_data (heap_size)
//
// A request word is taken when start is high and busy is low. The block then
// walks the free list (allocate) or the used table (free), one entry per cycle.
// The walk ends at the first free block that fits, or at the used record whose payload
// address matches; the result word appears in the same cycle as busy falls.
// Reset restores a 4096-byte heap as one free block; a config write rebuilds it.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  ffba_pkg::req_t             req,
    output logic                       done,
    output ffba_pkg::rsp_t             rsp,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [ffba_pkg::HEAP_W-1:0] cfg_data
);
    import ffba_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  cfg_we;

    // Configuration is taken only while no walk is in progress.
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    // The controller sequences load, walk steps and the final update.
    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the free list, used table and the result register.
    ffba_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rsp      (rsp),
        .done     (done)
    );

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ffba_pkg::*;

    // Kinds of rows in the directed table: a request word or a heap size write.
    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        op;
        logic [15:0] size;
        logic [15:0] addr;       // free address, or the heap size for a write
        int          stride;     // added to addr on each repeat
        int          reps;
        bit          typed;      // expected result written in the row
        rsp_t        want;
    } row_t;

    typedef struct {
        bit   typed;
        rsp_t want;
    } hint_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    first_fit_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the allocator state, kept in step with the block.
    logic [15:0] heap_bytes;
    logic [15:0] free_start [MAX_FREE_BLOCKS];
    logic [15:0] free_bytes [MAX_FREE_BLOCKS];
    int          free_count;
    logic [15:0] used_start [MAX_USED_BLOCKS];
    logic [15:0] used_bytes [MAX_USED_BLOCKS];
    bit          used_live  [MAX_USED_BLOCKS];

    rsp_t  pending_rsp[$];
    hint_t hint_q[$];
    int    words_taken;
    int    cfg_taken;
    int    mismatches;
    int    n_status [4];
    int    n_cfg;

    // Sender burst state.
    int burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void rebuild_heap(logic [15:0] bytes);
        heap_bytes = bytes;
        for (int i = 0; i < MAX_FREE_BLOCKS; i++)
        begin
            free_start[i] = '0;
            free_bytes[i] = '0;
        end
        for (int i = 0; i < MAX_USED_BLOCKS; i++)
            used_live[i] = 1'b0;
        free_bytes[0] = (bytes > HEADER_BYTES) ? 16'(bytes - HEADER_BYTES) : 16'd0;
        free_count = 1;
    endfunction

    // Computes the response word for one request and updates the shadow heap.
    function automatic rsp_t heap_update(req_t r);
        rsp_t o;
        int   fit;
        int   slot;
        int   hit;
        int   size;
        int   blk_start;
        int   blk_bytes;
        o.payload_addr = '0;
        o.status = ST_OK;
        if (r.op == OP_ALLOC)
        begin
            size = r.req_size;
            fit = -1;
            slot = -1;
            if (size == 0)
            begin
                o.status = ST_NO_FIT;
                return o;
            end
            for (int i = 0; i < free_count; i++)
                if (fit < 0 && free_bytes[i] >= size)
                    fit = i;
            if (fit < 0)
            begin
                o.status = ST_NO_FIT;
                return o;
            end
            for (int i = 0; i < MAX_USED_BLOCKS; i++)
                if (slot < 0 && !used_live[i])
                    slot = i;
            if (slot < 0)
            begin
                o.status = ST_FULL;
                return o;
            end
            blk_start = free_start[fit];
            blk_bytes = free_bytes[fit];
            if (blk_bytes > size + HEADER_BYTES)
            begin
                // The leftover piece keeps the block's position in the list.
                free_start[fit] = 16'(blk_start + HEADER_BYTES + size);
                free_bytes[fit] = 16'(blk_bytes - size - HEADER_BYTES);
                blk_bytes = size;
            end
            else
            begin
                for (int i = fit; i + 1 < free_count; i++)
                begin
                    free_start[i] = free_start[i + 1];
                    free_bytes[i] = free_bytes[i + 1];
                end
                free_count--;
            end
            used_start[slot] = 16'(blk_start);
            used_bytes[slot] = 16'(blk_bytes);
            used_live[slot] = 1'b1;
            o.payload_addr = 16'(blk_start + HEADER_BYTES);
        end
        else
        begin
            hit = -1;
            for (int i = 0; i < MAX_USED_BLOCKS; i++)
                if (hit < 0 && used_live[i] && 16'(used_start[i] + HEADER_BYTES) == r.free_addr)
                    hit = i;
            if (hit < 0)
                o.status = ST_UNKNOWN;
            else if (free_count >= MAX_FREE_BLOCKS)
                o.status = ST_FULL;
            else
            begin
                // Freed blocks go to the head of the list with no merging.
                for (int i = free_count; i > 0; i--)
                begin
                    free_start[i] = free_start[i - 1];
                    free_bytes[i] = free_bytes[i - 1];
                end
                free_start[0] = used_start[hit];
                free_bytes[0] = used_bytes[hit];
                free_count++;
                used_live[hit] = 1'b0;
            end
        end
        return o;
    endfunction

    // Everything on the outputs is sampled here at the rising edge. The check of
    // a result word comes before the prediction of a word taken at the same edge,
    // although the queue order would make either order correct.
    always @(posedge clk)
    begin
        rsp_t  want;
        rsp_t  pred;
        hint_t h;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result word with nothing expected: addr=%0d status=%0d",
                             rsp.payload_addr, rsp.status);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.payload_addr !== want.payload_addr || rsp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                                 want.payload_addr, want.status,
                                 rsp.payload_addr, rsp.status);
                end
                n_status[want.status]++;
            end
        end
        if (rst_n && start && !busy)
        begin
            pred = heap_update(req);
            h = hint_q.pop_front();
            // A row with a written-in answer is checked against that answer.
            pending_rsp.push_back(h.typed ? h.want : pred);
            words_taken++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            rebuild_heap(cfg_data);
            cfg_taken++;
            n_cfg++;
        end
    end

    // Sends one request word and returns at the falling edge after it was taken.
    // The sender works in bursts; between bursts start drops for a random gap.
    task automatic issue(req_t r, bit typed, rsp_t want);
        int    taken_mark;
        hint_t h;
        h.typed = typed;
        h.want = want;
        hint_q.push_back(h);
        taken_mark = words_taken;
        start <= 1'b1;
        req <= r;
        do @(negedge clk); while (words_taken == taken_mark);
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
        end
    endtask

    // Lets the block drain, then writes the heap size while it is idle.
    task automatic write_heap(logic [15:0] bytes);
        int taken_mark;
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        taken_mark = cfg_taken;
        cfg_valid <= 1'b1;
        cfg_data <= bytes;
        do @(negedge clk); while (cfg_taken == taken_mark);
        cfg_valid <= 1'b0;
    endtask

    // Picks the payload offset of a currently allocated block, or a random address if none is.
    function automatic logic [15:0] live_addr();
        int idx[$];
        for (int i = 0; i < MAX_USED_BLOCKS; i++)
            if (used_live[i])
                idx.push_back(i);
        if (idx.size() == 0)
            return 16'($urandom());
        return 16'(used_start[idx[$urandom_range(0, idx.size() - 1)]] + HEADER_BYTES);
    endfunction

    function automatic rsp_t mk(logic [15:0] a, logic [1:0] s);
        rsp_t o;
        o.payload_addr = a;
        o.status = s;
        return o;
    endfunction

    function automatic row_t rq(logic op, logic [15:0] size, logic [15:0] addr,
                                bit typed, rsp_t want);
        row_t w;
        w.kind = ROW_REQ;
        w.op = op;
        w.size = size;
        w.addr = addr;
        w.stride = 0;
        w.reps = 1;
        w.typed = typed;
        w.want = want;
        return w;
    endfunction

    function automatic row_t cf(logic [15:0] bytes);
        row_t w;
        w = rq(OP_ALLOC, 0, bytes, 0, mk(0, ST_OK));
        w.kind = ROW_CFG;
        return w;
    endfunction

    initial
    begin
        row_t        plan[$];
        row_t        w;
        req_t        r;
        logic [15:0] phase_heap [8];
        int          per_phase;
        int          pick;
        int          span;

        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        words_taken = 0;
        cfg_taken = 0;
        mismatches = 0;
        n_cfg = 0;
        n_status = '{default: 0};
        burst_left = 10;
        rebuild_heap(HEAP_RESET);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting from the 4096-byte heap left by reset.
        plan.push_back(rq(OP_ALLOC, 16'd0, 0, 1, mk(0, ST_NO_FIT)));       // zero size
        plan.push_back(rq(OP_ALLOC, 16'hFFFF, 0, 1, mk(0, ST_NO_FIT)));    // no fit
        plan.push_back(rq(OP_ALLOC, 16'd1, 0, 1, mk(16, ST_OK)));          // split
        plan.push_back(rq(OP_FREE, 0, 16'hFFFF, 1, mk(0, ST_UNKNOWN)));    // unknown
        plan.push_back(rq(OP_FREE, 0, 16'd16, 1, mk(0, ST_OK)));
        plan.push_back(rq(OP_FREE, 0, 16'd16, 1, mk(0, ST_UNKNOWN)));      // double free
        plan.push_back(rq(OP_ALLOC, 16'd1, 0, 1, mk(16, ST_OK)));          // exact fit
        plan.push_back(rq(OP_ALLOC, 16'd4063, 0, 1, mk(33, ST_OK)));       // exact fit of the rest
        plan.push_back(rq(OP_ALLOC, 16'd1, 0, 1, mk(0, ST_NO_FIT)));       // list empty
        plan.push_back(cf(16'd16));                                         // tiny heap
        plan.push_back(rq(OP_ALLOC, 16'd1, 0, 1, mk(0, ST_NO_FIT)));
        plan.push_back(rq(OP_FREE, 0, 16'd0, 1, mk(0, ST_UNKNOWN)));
        plan.push_back(cf(16'hFFFF));                                       // largest heap
        plan.push_back(rq(OP_ALLOC, 16'd65519, 0, 1, mk(16, ST_OK)));
        plan.push_back(rq(OP_FREE, 0, 16'd16, 1, mk(0, ST_OK)));
        plan.push_back(rq(OP_ALLOC, 16'h8000, 0, 0, mk(0, ST_OK)));
        plan.push_back(rq(OP_ALLOC, 16'h7FCF, 0, 0, mk(0, ST_OK)));
        plan.push_back(cf(16'd4096));
        // Sixteen small grants fill the used table; the next one finds it full.
        w = rq(OP_ALLOC, 16'd1, 0, 0, mk(0, ST_OK));
        w.reps = MAX_USED_BLOCKS;
        plan.push_back(w);
        plan.push_back(rq(OP_ALLOC, 16'd1, 0, 1, mk(0, ST_FULL)));
        // Fifteen frees fill the free list, so the last free is refused.
        w = rq(OP_FREE, 0, 16'd16, 0, mk(0, ST_OK));
        w.stride = 17;
        w.reps = MAX_FREE_BLOCKS - 1;
        plan.push_back(w);
        plan.push_back(rq(OP_FREE, 0, 16'd271, 1, mk(0, ST_FULL)));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_heap(plan[i].addr);
            else
                for (int k = 0; k < plan[i].reps; k++)
                begin
                    r.op = plan[i].op;
                    r.req_size = plan[i].size;
                    r.free_addr = 16'(plan[i].addr + k * plan[i].stride);
                    issue(r, plan[i].typed, plan[i].want);
                end
        end

        // Random part: several heap sizes, mostly allocate/free traffic on live
        // blocks with a share of junk requests mixed in.
        phase_heap[0] = 16'd4096;
        phase_heap[1] = 16'hFFFF;
        phase_heap[2] = 16'd16;
        phase_heap[3] = 16'($urandom_range(17, 64));
        phase_heap[4] = 16'($urandom_range(16, 65535));
        phase_heap[5] = 16'd300;
        phase_heap[6] = 16'($urandom_range(1000, 20000));
        phase_heap[7] = 16'd4096;
        per_phase = 1750 / 8;
        for (int p = 0; p < 8; p++)
        begin
            write_heap(phase_heap[p]);
            span = (heap_bytes > 128) ? heap_bytes / 12 : 8;
            for (int n = 0; n < per_phase; n++)
            begin
                pick = $urandom_range(0, 99);
                r.req_size = 16'($urandom());
                r.free_addr = 16'($urandom());
                if (pick < 48)
                begin
                    r.op = OP_ALLOC;
                    r.req_size = 16'($urandom_range(1, span));
                end
                else if (pick < 88)
                begin
                    r.op = OP_FREE;
                    r.free_addr = live_addr();
                end
                else
                    r.op = 1'($urandom());
                issue(r, 0, mk(0, ST_OK));
                // Once in the middle the sender holds off until all answers are in.
                if (p == 4 && n == per_phase / 2)
                begin
                    start <= 1'b0;
                    while (pending_rsp.size() != 0)
                        @(negedge clk);
                end
            end
        end

        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Covered %0d request words over %0d heap sizes: ok %0d, no fit %0d,",
                 words_taken, n_cfg, n_status[ST_OK], n_status[ST_NO_FIT]);
        $display("unknown address %0d, table full %0d; %0d mismatches.",
                 n_status[ST_UNKNOWN], n_status[ST_FULL], mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
